/* hdl/fpwf_pkg.sv */
// Shared constants for the first positive window finder.
`default_nettype none

package fpwf_pkg;

   localparam int SAMPLE_W    = 16;
   localparam int ROW_W       = 12;
   localparam int ROW_COUNT_W = 13;
   localparam int MAX_ROWS    = 4096;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 13;

   localparam logic [CSR_IDX_W-1:0] REG_ROW_COUNT    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_COLUMN_COUNT = 2'd1;

   localparam logic [ROW_COUNT_W-1:0] ROW_COUNT_RESET = 13'd3;
   localparam int                     COLUMN_COUNT_RESET = 3;

endpackage

`default_nettype wire

/* hdl/first_positive_window_finder.sv */
// Top level: streaming search for the first all-positive square window of a frame.
// The result register is loaded from the update stage when that stage advances with the frame's last beat.
// Throughput: one sample beat per cycle, set by the read-modify-write of the per-column
//   run store (a same-column bypass covers one-column frames); stalls while a last beat waits on a held result.
// Reset: synchronous, active high; clears positions, runs, the hit record and the
//   per-column valid bits, and sets both size registers to 3. No clearing pass.
`default_nettype none

module first_positive_window_finder #(
   parameter int MAX_COLUMNS = 128,
   parameter int WINDOW      = 3,
   localparam int COL_W      = $clog2(MAX_COLUMNS)
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_valid,
   output logic                                req_ready,
   input  wire  signed [fpwf_pkg::SAMPLE_W-1:0] req_sample,
   output logic                                rsp_valid,
   input  wire                                 rsp_ready,
   output logic                                rsp_found,
   output logic [fpwf_pkg::ROW_W-1:0]          rsp_top_row,
   output logic [COL_W-1:0]                    rsp_left_column,
   input  wire                                 csr_valid,
   output logic                                csr_ready,
   input  wire  [fpwf_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire  [fpwf_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int CC_W  = $clog2(MAX_COLUMNS + 1);
   localparam int RUN_W = $clog2(WINDOW + 1);
   localparam int ROW_W = fpwf_pkg::ROW_W;
   localparam int RC_W  = fpwf_pkg::ROW_COUNT_W;

   localparam logic [RUN_W-1:0] RUN_FULL = RUN_W'(WINDOW);

   // configuration
   logic [RC_W-1:0] row_count_ff;
   logic [CC_W-1:0] column_count_ff;
   logic [RC_W-1:0] rows_eff;
   logic [CC_W-1:0] cols_eff;

   // position counters (input side)
   logic [COL_W-1:0] column_position_ff;
   logic [ROW_W-1:0] row_position_ff;
   logic [CC_W-1:0]  col_next;
   logic [RC_W-1:0]  row_next;
   logic             end_of_row;
   logic             end_of_frame;
   logic             accept;

   // run store
   logic [RUN_W-1:0]       run_mem [MAX_COLUMNS];
   logic [MAX_COLUMNS-1:0] run_vld_ff;
   logic [RUN_W-1:0]       mem_rd_ff;
   logic                   rd_vld_ff;
   logic                   byp_clr_ff;
   logic                   byp_hit_ff;
   logic [RUN_W-1:0]       byp_run_ff;

   // update stage
   logic             s_valid_ff;
   logic             s_pos_ff;
   logic [COL_W-1:0] s_col_ff;
   logic [ROW_W-1:0] s_row_ff;
   logic             s_last_ff;
   logic             s_go;
   logic [RUN_W-1:0] old_run;
   logic [RUN_W-1:0] v_run;
   logic [RUN_W-1:0] h_base;
   logic [RUN_W-1:0] h_run_in;
   logic [RUN_W-1:0] h_run_ff;
   logic             hit_now;
   logic             hit_seen_ff;
   logic [ROW_W-1:0] hit_row_ff;
   logic [COL_W-1:0] hit_col_ff;
   logic             hit_seen_in;
   logic [ROW_W-1:0] hit_row_in;
   logic [COL_W-1:0] hit_col_in;

   // result register
   logic             rsp_valid_ff;
   logic             rsp_found_ff;
   logic [ROW_W-1:0] rsp_top_row_ff;
   logic [COL_W-1:0] rsp_left_column_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff    <= fpwf_pkg::ROW_COUNT_RESET;
         column_count_ff <= CC_W'(fpwf_pkg::COLUMN_COUNT_RESET);
      end else if (csr_valid) begin
         unique case (csr_index)
            fpwf_pkg::REG_ROW_COUNT:    row_count_ff    <= csr_wdata[RC_W-1:0];
            fpwf_pkg::REG_COLUMN_COUNT: column_count_ff <= csr_wdata[CC_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (row_count_ff == '0) begin
         rows_eff = RC_W'(1);
      end else if (row_count_ff > RC_W'(fpwf_pkg::MAX_ROWS)) begin
         rows_eff = RC_W'(fpwf_pkg::MAX_ROWS);
      end else begin
         rows_eff = row_count_ff;
      end
      if (column_count_ff == '0) begin
         cols_eff = CC_W'(1);
      end else if (column_count_ff > CC_W'(MAX_COLUMNS)) begin
         cols_eff = CC_W'(MAX_COLUMNS);
      end else begin
         cols_eff = column_count_ff;
      end
      col_next     = CC_W'(column_position_ff) + CC_W'(1);
      row_next     = RC_W'(row_position_ff) + RC_W'(1);
      end_of_row   = col_next >= cols_eff;
      end_of_frame = end_of_row && (row_next >= rows_eff);
   end

   assign s_go      = s_valid_ff && (!s_last_ff || !rsp_valid_ff || rsp_ready);
   assign req_ready = !s_valid_ff || s_go;
   assign accept    = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         column_position_ff <= '0;
         row_position_ff    <= '0;
      end else if (accept) begin
         if (end_of_row) begin
            column_position_ff <= '0;
            if (end_of_frame) begin
               row_position_ff <= '0;
            end else begin
               row_position_ff <= row_position_ff + ROW_W'(1);
            end
         end else begin
            column_position_ff <= column_position_ff + COL_W'(1);
         end
      end
   end

   // store read and write; payload needs no reset
   always_ff @(posedge clock) begin
      if (s_go) begin
         run_mem[s_col_ff] <= v_run;
      end
      if (accept) begin
         mem_rd_ff  <= run_mem[column_position_ff];
         rd_vld_ff  <= run_vld_ff[column_position_ff];
         byp_clr_ff <= s_go && s_last_ff;
         byp_hit_ff <= s_go && (s_col_ff == column_position_ff);
         byp_run_ff <= v_run;
         s_pos_ff   <= (req_sample > 0);
         s_col_ff   <= column_position_ff;
         s_row_ff   <= row_position_ff;
         s_last_ff  <= end_of_frame;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_vld_ff <= '0;
         s_valid_ff <= 1'b0;
      end else begin
         if (s_go && s_last_ff) begin
            run_vld_ff <= '0;
         end else if (s_go) begin
            run_vld_ff[s_col_ff] <= 1'b1;
         end
         if (accept) begin
            s_valid_ff <= 1'b1;
         end else if (s_go) begin
            s_valid_ff <= 1'b0;
         end
      end
   end

   always_comb begin
      if (byp_clr_ff) begin
         old_run = '0;
      end else if (byp_hit_ff) begin
         old_run = byp_run_ff;
      end else if (rd_vld_ff) begin
         old_run = mem_rd_ff;
      end else begin
         old_run = '0;
      end
      if (!s_pos_ff) begin
         v_run = '0;
      end else if (old_run >= RUN_FULL) begin
         v_run = RUN_FULL;
      end else begin
         v_run = old_run + RUN_W'(1);
      end
      h_base = (s_col_ff == '0) ? '0 : h_run_ff;
      if (v_run >= RUN_FULL) begin
         h_run_in = (h_base >= RUN_FULL) ? RUN_FULL : h_base + RUN_W'(1);
      end else begin
         h_run_in = '0;
      end
      hit_now = (h_run_in >= RUN_FULL) && !hit_seen_ff &&
                (s_row_ff >= ROW_W'(WINDOW - 1)) && (s_col_ff >= COL_W'(WINDOW - 1));
      hit_seen_in = hit_seen_ff;
      hit_row_in  = hit_row_ff;
      hit_col_in  = hit_col_ff;
      if (hit_now) begin
         hit_seen_in = 1'b1;
         hit_row_in  = s_row_ff - ROW_W'(WINDOW - 1);
         hit_col_in  = s_col_ff - COL_W'(WINDOW - 1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         h_run_ff    <= '0;
         hit_seen_ff <= 1'b0;
         hit_row_ff  <= '0;
         hit_col_ff  <= '0;
      end else if (s_go) begin
         if (s_last_ff) begin
            h_run_ff    <= '0;
            hit_seen_ff <= 1'b0;
            hit_row_ff  <= '0;
            hit_col_ff  <= '0;
         end else begin
            h_run_ff    <= h_run_in;
            hit_seen_ff <= hit_seen_in;
            hit_row_ff  <= hit_row_in;
            hit_col_ff  <= hit_col_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s_go && s_last_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (s_go && s_last_ff) begin
         rsp_found_ff       <= hit_seen_in;
         rsp_top_row_ff     <= hit_row_in;
         rsp_left_column_ff <= hit_col_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_top_row     = rsp_top_row_ff;
   assign rsp_left_column = rsp_left_column_ff;

endmodule

`default_nettype wire

/* hdl/fpwf_checker.sv */
// Port-level checks for the first positive window finder, with its bind.
`default_nettype none

module fpwf_checker #(
   parameter int COL_W = 7
) (
   input wire                         clock,
   input wire                         reset,
   input wire                         req_ready,
   input wire                         rsp_valid,
   input wire                         rsp_ready,
   input wire                         rsp_found,
   input wire [fpwf_pkg::ROW_W-1:0]   rsp_top_row,
   input wire [COL_W-1:0]             rsp_left_column
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_found) &&
      $stable(rsp_top_row) && $stable(rsp_left_column))
      else $error("stalled result beat changed");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_top_row == '0 && rsp_left_column == '0)
      else $error("corner nonzero without a hit");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled while result side is free");

endmodule

bind first_positive_window_finder fpwf_checker #(.COL_W(COL_W)) u_fpwf_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_found      (rsp_found),
   .rsp_top_row    (rsp_top_row),
   .rsp_left_column(rsp_left_column)
);

`default_nettype wire
